// ===== rtl/sai_pkg.sv =====
// sai_pkg: shared types and constants for the sorted table block
// field widths, operation and status codes, and the control bundle sent to the cells
// no dependencies
package sai_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned PosW       = 10;
  localparam int unsigned SlotW      = 11;
  localparam int unsigned CountOutW  = 11;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 56;

  localparam int unsigned DefaultTableDepth = 1024;

  // operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_OUT_RANGE = 2'd2;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_array_insert_remove.sv =====
// sorted_array_insert_remove: sorted table of signed values with ordered insert
// and positional remove, built as a row of shifting cells plus a small sequencer
// depends on sai_pkg and sai_cell
//
// usage
//   s_axis carries one operation per item: tuser selects insert or remove,
//   tdata holds the value to insert and the index to remove.
//   m_axis returns one result per item: slot used, removed value, entry count
//   after the item and a status (ok, table full, index out of range).
//
// timing
//   one item is in flight at a time; s_axis_tready is high only while idle.
//   the cell row shifts the whole table at once in the apply step. an insert then
//   finds its slot by a bit-serial search over the registered compare flags,
//   one bit of the slot per cycle, so CW = $clog2(TableDepth+1) steps.
//   a legal insert passes the apply step, the search and the final step before
//   the next acceptance; a remove or a rejected item goes from apply to final.
//   the final step loads the result into the output register once it is free.
//
// reset and stall
//   reset empties the table (count zero); entry storage is not cleared.
//   the result sits in an output register until m_axis_tready; a new item
//   may be accepted meanwhile, and it waits in its final step until the
//   output register is free.
module sorted_array_insert_remove #(
  parameter int unsigned TableDepth = sai_pkg::DefaultTableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] value, [41:32] position, [47:42] zero
  input  logic [sai_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [10:0] slot, [42:11] removed_value, [53:43] entry_count, [55:54] status
  output logic [sai_pkg::OutDataW-1:0]  m_axis_tdata
);
  import sai_pkg::*;

  localparam int unsigned CW   = $clog2(TableDepth + 1);
  localparam int unsigned IW   = $clog2(TableDepth);
  localparam int unsigned KW   = $clog2(CW);
  localparam int unsigned CmpW = (CW > PosW) ? CW : PosW;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_APPLY  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]               state_q, state_d;
  logic                     kind_q;
  logic signed [ValueW-1:0] value_q;
  logic [PosW-1:0]          pos_q;
  logic [CW-1:0]            count_q, count_d;
  logic [TableDepth-1:0]    flags_q;
  logic [CW-1:0]            srch_q, srch_d;
  logic [KW-1:0]            bit_q, bit_d;

  // staged result of the item in flight
  logic [SlotW-1:0]         res_slot_q, res_slot_d;
  logic signed [ValueW-1:0] res_removed_q;
  logic [StatusW-1:0]       res_status_q;

  // output register
  logic                     out_valid_q;
  logic [SlotW-1:0]         out_slot_q;
  logic signed [ValueW-1:0] out_removed_q;
  logic [CountOutW-1:0]     out_count_q;
  logic [StatusW-1:0]       out_status_q;

  logic                     in_accept;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     out_free;
  logic [CW-1:0]            probe;
  logic                     probe_take;
  cell_ctrl_t               cell_ctrl;

  logic                     cell_lt    [TableDepth];
  logic signed [ValueW-1:0] cell_entry [TableDepth];
  logic [TableDepth-1:0]    lt_vec;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // legality of the item held in the staging registers
  assign ins_ok = (kind_q == KIND_INSERT) && (count_q != CW'(TableDepth));
  assign rem_ok = (kind_q == KIND_REMOVE) && (CmpW'(pos_q) < CmpW'(count_q));

  // the row only moves in the apply step of a legal item
  assign cell_ctrl.insert = (state_q == ST_APPLY) && ins_ok;
  assign cell_ctrl.remove = (state_q == ST_APPLY) && rem_ok;
  assign cell_ctrl.value  = value_q;

  // cell row
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    logic                     prev_lt;
    logic signed [ValueW-1:0] lower_entry;
    logic signed [ValueW-1:0] upper_entry;

    if (g == 0) begin : g_first
      assign prev_lt     = 1'b1;
      assign lower_entry = value_q;
    end else begin : g_mid
      assign prev_lt     = cell_lt[g-1];
      assign lower_entry = cell_entry[g-1];
    end

    if (g == TableDepth - 1) begin : g_last
      assign upper_entry = cell_entry[g];
    end else begin : g_inner
      assign upper_entry = cell_entry[g+1];
    end

    sai_cell #(
      .Index  (g),
      .CountW (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .count_i       (count_q),
      .pos_i         (CW'(pos_q)),
      .prev_lt_i     (prev_lt),
      .lower_entry_i (lower_entry),
      .upper_entry_i (upper_entry),
      .lt_o          (cell_lt[g]),
      .entry_o       (cell_entry[g])
    );

    assign lt_vec[g] = cell_lt[g];
  end

  // slot search: the flags form a run of ones from index zero, so the slot
  // is the length of that run, found one bit at a time from the top
  assign probe      = srch_q | (CW'(1) << bit_q);
  assign probe_take = (probe <= CW'(TableDepth)) && flags_q[IW'(probe - CW'(1))];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    srch_d     = srch_q;
    bit_d      = bit_q;
    res_slot_d = res_slot_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        srch_d     = '0;
        bit_d      = KW'(CW - 1);
        res_slot_d = '0;
        if (ins_ok) begin
          count_d = count_q + CW'(1);
          state_d = ST_SEARCH;
        end else if (rem_ok) begin
          count_d    = count_q - CW'(1);
          res_slot_d = SlotW'(pos_q);
          state_d    = ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SEARCH: begin
        if (probe_take) begin
          srch_d = probe;
        end
        if (bit_q == '0) begin
          res_slot_d = probe_take ? SlotW'(probe) : SlotW'(srch_q);
          state_d    = ST_DONE;
        end else begin
          bit_d = bit_q - KW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    srch_q     <= srch_d;
    bit_q      <= bit_d;
    res_slot_q <= res_slot_d;
    if (in_accept) begin
      kind_q  <= s_axis_tuser;
      value_q <= s_axis_tdata[ValueW-1:0];
      pos_q   <= s_axis_tdata[ValueW+PosW-1:ValueW];
    end
    if (state_q == ST_APPLY) begin
      flags_q <= lt_vec;
      if (rem_ok) begin
        res_removed_q <= cell_entry[IW'(pos_q)];
        res_status_q  <= STATUS_OK;
      end else begin
        res_removed_q <= '0;
        if (kind_q == KIND_INSERT) begin
          res_status_q <= ins_ok ? STATUS_OK : STATUS_FULL;
        end else begin
          res_status_q <= STATUS_OUT_RANGE;
        end
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_slot_q    <= res_slot_q;
      out_removed_q <= res_removed_q;
      out_count_q   <= CountOutW'(count_q);
      out_status_q  <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_status_q, out_count_q, out_removed_q, out_slot_q};

  // the count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TableDepth))
    else $error("entry count above table depth");

  // the apply step always hands over to the search or the final step
  a_apply_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> (state_q == ST_SEARCH || state_q == ST_DONE))
    else $error("apply step not followed by search or finish");

  // the partial slot never runs past the entries held
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (srch_q < count_q))
    else $error("slot search beyond held entries");

  // a rejected item reports slot zero and no removed value
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != STATUS_OK) |-> (out_slot_q == '0 && out_removed_q == '0))
    else $error("error result carries slot or value");

endmodule

// ===== rtl/sai_cell.sv =====
// sai_cell: one slot of the sorted row, holds a single entry
// compares its entry with the broadcast value and shifts with its neighbors
// depends on sai_pkg
module sai_cell #(
  parameter int unsigned Index  = 0,
  parameter int unsigned CountW = 11
) (
  input  logic                              clk_i,
  input  sai_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CountW-1:0]                 count_i,
  input  logic [CountW-1:0]                 pos_i,
  input  logic                              prev_lt_i,
  input  logic signed [sai_pkg::ValueW-1:0] lower_entry_i,
  input  logic signed [sai_pkg::ValueW-1:0] upper_entry_i,
  output logic                              lt_o,
  output logic signed [sai_pkg::ValueW-1:0] entry_o
);
  import sai_pkg::*;

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     held;

  // entry is live when its index is below the count
  assign held = CountW'(Index) < count_i;
  assign lt_o = held && (entry_q < ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && !lt_o) begin
      // first cell not below the value takes it, later ones take the lower neighbor
      entry_d = prev_lt_i ? ctrl_i.value : lower_entry_i;
    end else if (ctrl_i.remove && (CountW'(Index) >= pos_i)) begin
      entry_d = upper_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
